// File: hw/rtl/bitmap_page_allocator_top_defines.svh
// Assertion macros for the page allocator.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Check an implication in the same cycle.
`define BPA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

  // Page numbers and page counts below the managed bound
  localparam int unsigned PAGE_W = 17;
  // Arithmetic width for page sums that may pass the bound
  localparam int unsigned CALC_W = PAGE_W + 1;

  localparam logic [1:0] MODE_ALLOC_ONE = 2'd0;
  localparam logic [1:0] MODE_ALLOC_RUN = 2'd1;
  localparam logic [1:0] MODE_FREE_ONE  = 2'd2;
  localparam logic [1:0] MODE_FREE_RUN  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK,
    ST_COUNT_RD,
    ST_COUNT,
    ST_DONE
  } bpa_state_e;

  // Control of the shared word unit
  typedef struct packed {
    logic inv;       // look at free bits instead of used bits
    logic set_bits;  // write mask bits to used instead of free
  } bpa_ctl_t;

endpackage

// File: hw/rtl/bitmap_page_allocator_top.sv
`timescale 1ns / 1ps
// After reset the bitmap is set to all used, word by word, before any request is taken.
// A request reads and checks each bitmap word scanned, steps past used pages inside a
// word while looking for a run, reads and rewrites each word marked, then responds.
// A nonzero total_pages write recounts the free pages word by word below the bound.
// One request at a time; the single-port bitmap read and the shared word unit set the pace.
// Reset is asynchronous, active low; every page reads as used and the bound is 0.
`include "bitmap_page_allocator_top_defines.svh"
module bitmap_page_allocator_top #(
  parameter int unsigned MAX_PAGES = 65536,
  parameter int unsigned BITMAP_WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,   // total_pages
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // page_index[19:0], count[36:20], zero[39:37]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // first_page[15:0], used_pages[32:16], free_pages[49:33]
  output logic        m_axis_tuser   // ok
);
  import bpa_pkg::*;

  localparam int unsigned WB = BITMAP_WORD_BITS;
  localparam int unsigned BW = $clog2(WB);
  localparam int unsigned TW = BW + 1;
  localparam int unsigned MAP_WORDS = MAX_PAGES / WB;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned WCW = PAGE_W - BW + 1;

  bpa_state_e state_q, state_d;
  logic [PAGE_W-1:0] n_q, n_d, n_new;
  logic [PAGE_W-1:0] free_q, free_d;
  logic [PAGE_W-1:0] count_q, count_d;
  logic [CALC_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CALC_W-1:0] run_q, run_d, rs_q, rs_d;
  logic [WCW-1:0]    wc_q, wc_d;
  logic [BW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              set_q, set_d;
  logic              ok_q, ok_d;
  logic [15:0]       first_q, first_d;
  logic              m_valid_q, m_valid_d;
  logic [55:0]       m_data_q, m_data_d;
  logic              m_ok_q, m_ok_d;

  logic              accept;
  logic [1:0]        req_mode;
  logic [19:0]       req_page;
  logic [PAGE_W-1:0] req_count, req_cnt;
  logic [20:0]       req_end;
  logic [CALC_W-1:0] free_hi;

  logic [CALC_W-1:0] base, next_base, seg_start, run_sum;
  logic [TW:0]       pos_end;
  logic              scan_hit, scan_word_end, scan_skip_end, word_last_n, word_last_hi;
  logic              clr_last, out_free;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WB-1:0]     mem_wdata, mem_rdata, unit_wdata;
  logic [TW-1:0]     unit_cnt, unit_tones;
  logic [BW-1:0]     unit_pos;
  bpa_ctl_t          unit_ctl;

  // Decode the request
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign req_mode  = s_axis_tuser;
  assign req_page  = s_axis_tdata[19:0];
  assign req_count = s_axis_tdata[36:20];
  assign req_cnt   = (req_mode == MODE_ALLOC_ONE || req_mode == MODE_FREE_ONE) ?
                     PAGE_W'(1) : req_count;
  assign req_end   = 21'(req_page) + 21'(req_cnt);
  assign free_hi   = (req_end > 21'(n_q)) ? CALC_W'(n_q) : CALC_W'(req_end);
  assign n_new     = (32'(cfg_wdata_i) > 32'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : cfg_wdata_i;

  // Scan and range decisions for the current word
  assign base          = CALC_W'(wc_q) << BW;
  assign next_base     = base + CALC_W'(WB);
  assign seg_start     = base + CALC_W'(pos_q);
  assign run_sum       = run_q + CALC_W'(unit_tones);
  assign scan_hit      = run_sum >= CALC_W'(count_q);
  assign pos_end       = (TW+1)'(pos_q) + (TW+1)'(unit_tones);
  assign scan_word_end = pos_end == (TW+1)'(WB);
  assign scan_skip_end = pos_end + (TW+1)'(1) >= (TW+1)'(WB);
  assign word_last_n   = next_base >= CALC_W'(n_q);
  assign word_last_hi  = next_base >= hi_q;
  assign clr_last      = clr_q == AW'(MAP_WORDS - 1);
  assign out_free      = !m_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_we_i) begin
          if (n_new != '0) state_d = ST_COUNT_RD;
        end else if (accept) begin
          if (req_mode == MODE_ALLOC_ONE || req_mode == MODE_ALLOC_RUN) begin
            state_d = (req_cnt == '0 || n_q == '0) ? ST_DONE : ST_SCAN_RD;
          end else begin
            state_d = (21'(req_page) >= 21'(free_hi)) ? ST_DONE : ST_MARK_RD;
          end
        end
      end
      ST_SCAN_RD:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_hit) begin
          state_d = ST_MARK_RD;
        end else if (scan_word_end || scan_skip_end) begin
          state_d = word_last_n ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_MARK_RD:  state_d = ST_MARK;
      ST_MARK:     state_d = word_last_hi ? ST_DONE : ST_MARK_RD;
      ST_COUNT_RD: state_d = ST_COUNT;
      ST_COUNT:    state_d = word_last_n ? ST_IDLE : ST_COUNT_RD;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    n_d       = n_q;
    free_d    = free_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    run_d     = run_q;
    rs_d      = rs_q;
    wc_d      = wc_q;
    pos_d     = pos_q;
    clr_d     = clr_q;
    set_d     = set_q;
    ok_d      = ok_q;
    first_d   = first_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_ok_d    = m_ok_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(wc_q);
    mem_wdata = unit_wdata;
    mem_re    = 1'b0;
    mem_raddr = AW'(wc_q);
    unit_ctl  = '{inv: !(state_q == ST_MARK && !set_q), set_bits: set_q};
    unit_pos  = (state_q == ST_SCAN) ? pos_q : '0;
    if (cfg_we_i) n_d = n_new;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '1;
        clr_d     = clr_q + AW'(1);
        free_d    = '0;
      end
      ST_IDLE: begin
        if (cfg_we_i) begin
          free_d = '0;
          wc_d   = '0;
          lo_d   = '0;
          hi_d   = CALC_W'(n_new);
        end else if (accept) begin
          first_d = '0;
          count_d = req_cnt;
          wc_d    = '0;
          pos_d   = '0;
          run_d   = '0;
          if (req_mode == MODE_ALLOC_ONE || req_mode == MODE_ALLOC_RUN) begin
            ok_d = 1'b0;
            lo_d = '0;
            hi_d = CALC_W'(n_q);
          end else begin
            ok_d  = 1'b1;
            set_d = 1'b0;
            lo_d  = CALC_W'(req_page[PAGE_W-1:0]);
            hi_d  = free_hi;
            wc_d  = WCW'(req_page[PAGE_W-1:BW]);
          end
        end
      end
      ST_SCAN_RD, ST_MARK_RD, ST_COUNT_RD: begin
        mem_re = 1'b1;
      end
      ST_SCAN: begin
        if (run_q == '0) rs_d = seg_start;
        if (scan_hit) begin
          ok_d    = 1'b1;
          first_d = (run_q == '0) ? seg_start[15:0] : rs_q[15:0];
          lo_d    = (run_q == '0) ? seg_start : rs_q;
          hi_d    = ((run_q == '0) ? seg_start : rs_q) + CALC_W'(count_q);
          wc_d    = WCW'(((run_q == '0) ? seg_start : rs_q) >> BW);
          set_d   = 1'b1;
        end else if (scan_word_end) begin
          run_d = run_sum;
          wc_d  = wc_q + WCW'(1);
          pos_d = '0;
        end else begin
          run_d = '0;
          if (scan_skip_end) begin
            wc_d  = wc_q + WCW'(1);
            pos_d = '0;
          end else begin
            pos_d = BW'(pos_end + (TW+1)'(1));
          end
        end
      end
      ST_MARK: begin
        mem_we = 1'b1;
        free_d = set_q ? (free_q - PAGE_W'(unit_cnt)) : (free_q + PAGE_W'(unit_cnt));
        wc_d   = wc_q + WCW'(1);
      end
      ST_COUNT: begin
        free_d = free_q + PAGE_W'(unit_cnt);
        wc_d   = wc_q + WCW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_ok_d    = ok_q;
          m_data_d  = {6'd0, free_q, PAGE_W'(n_q - free_q), first_q};
        end
      end
      default: ;
    endcase
  end

  // Hold control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      n_q       <= '0;
      free_q    <= '0;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      free_q    <= free_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    run_q    <= run_d;
    rs_q     <= rs_d;
    wc_q     <= wc_d;
    pos_q    <= pos_d;
    set_q    <= set_d;
    ok_q     <= ok_d;
    first_q  <= first_d;
    m_data_q <= m_data_d;
    m_ok_q   <= m_ok_d;
  end

  bpa_bitmap_mem #(
    .WB   (WB),
    .DEPTH(MAP_WORDS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  bpa_word_unit #(
    .WB(WB),
    .BW(BW),
    .TW(TW)
  ) u_unit (
    .data_i (mem_rdata),
    .base_i (base),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .pos_i  (unit_pos),
    .ctl_i  (unit_ctl),
    .wdata_o(unit_wdata),
    .cnt_o  (unit_cnt),
    .tones_o(unit_tones)
  );

  // Hold off requests while the bound is being written
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_we_i;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_ok_q;

  `BPA_ASSERT(a_free_le_bound, state_q == ST_IDLE, free_q <= n_q, "free count above bound")
  `BPA_ASSERT_NEXT(a_busy_after_req, accept, !s_axis_tready, "ready right after a request")
  `BPA_ASSERT(a_fail_page_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:0] == 16'd0,
              "failed request with nonzero page")

endmodule

// File: hw/rtl/bpa_bitmap_mem.sv
`timescale 1ns / 1ps
module bpa_bitmap_mem #(
  parameter int unsigned WB = 32,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [WB-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [WB-1:0] rdata_o
);

  logic [WB-1:0] mem_q [DEPTH];
  logic [WB-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one word, hold it until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bpa_word_unit.sv
`timescale 1ns / 1ps
module bpa_word_unit #(
  parameter int unsigned WB = 32,
  parameter int unsigned BW = 5,
  parameter int unsigned TW = 6
) (
  input  logic [WB-1:0]                data_i,
  input  logic [bpa_pkg::CALC_W-1:0]   base_i,
  input  logic [bpa_pkg::CALC_W-1:0]   lo_i,
  input  logic [bpa_pkg::CALC_W-1:0]   hi_i,
  input  logic [BW-1:0]                pos_i,
  input  bpa_pkg::bpa_ctl_t            ctl_i,
  output logic [WB-1:0]                wdata_o,
  output logic [TW-1:0]                cnt_o,
  output logic [TW-1:0]                tones_o
);
  import bpa_pkg::*;

  logic [CALC_W-1:0] lo_off, hi_off;
  logic [TW-1:0]     lo_rel, hi_rel;
  logic [WB:0]       ones, mask_w;
  logic [WB-1:0]     mask, sel, shifted;

  // Clamp the range bounds to this word
  always_comb begin
    lo_off = lo_i - base_i;
    hi_off = hi_i - base_i;
    if (lo_i <= base_i) begin
      lo_rel = '0;
    end else if (lo_off >= CALC_W'(WB)) begin
      lo_rel = TW'(WB);
    end else begin
      lo_rel = lo_off[TW-1:0];
    end
    if (hi_i <= base_i) begin
      hi_rel = '0;
    end else if (hi_off >= CALC_W'(WB)) begin
      hi_rel = TW'(WB);
    end else begin
      hi_rel = hi_off[TW-1:0];
    end
  end

  // Build the in-range mask
  assign ones   = '1;
  assign mask_w = ~(ones << hi_rel) & (ones << lo_rel);
  assign mask   = mask_w[WB-1:0];

  assign sel     = (ctl_i.inv ? ~data_i : data_i) & mask;
  assign wdata_o = ctl_i.set_bits ? (data_i | mask) : (data_i & ~mask);
  assign cnt_o   = TW'($countones(sel));

  // Count the free bits in a row starting at pos
  assign shifted = sel >> pos_i;
  always_comb begin
    tones_o = TW'(WB);
    for (int i = WB - 1; i >= 0; i--) begin
      if (!shifted[i]) begin
        tones_o = TW'(i);
      end
    end
  end

endmodule
